// ===== hdl/sptab_pkg.sv =====
`default_nettype none
package sptab_pkg;

    localparam int CAPACITY = 16;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [3:0]  level;
        logic [6:0]  age;
        logic [15:0] id;
    } t_rec;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_rec          wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_mem_req;

endpackage
`default_nettype wire

// ===== hdl/sptab_mem.sv =====
`default_nettype none
module sptab_mem (
    input  wire                       i_clk,
    input  wire sptab_pkg::t_mem_req  i_req,
    output sptab_pkg::t_rec           o_rdata
);

    sptab_pkg::t_rec r_mem [sptab_pkg::CAPACITY];
    sptab_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hdl/sptab_ctrl.sv =====
`default_nettype none
module sptab_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire                       i_req_type,
    input  wire  [3:0]                i_level,
    input  wire  [6:0]                i_age,
    input  wire  [15:0]               i_member_id,
    input  wire  [3:0]                i_read_rank,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output logic [1:0]                o_status,
    output logic [3:0]                o_rank,
    output logic [3:0]                o_out_level,
    output logic [6:0]                o_out_age,
    output logic [15:0]               o_out_id,
    output logic [4:0]                o_fill_count,
    output sptab_pkg::t_mem_req       o_mem_req,
    input  wire sptab_pkg::t_rec      i_mem_rdata
);

    localparam int CW = sptab_pkg::CW;
    localparam int AW = sptab_pkg::AW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_RWAIT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    sptab_pkg::t_rec r_new, n_new;
    logic [1:0]      r_res_status, n_res_status;
    logic [3:0]      r_res_rank, n_res_rank;
    sptab_pkg::t_rec r_res_rec, n_res_rec;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_out_status;
    logic [3:0]      r_out_rank;
    sptab_pkg::t_rec r_out_rec;
    logic            load_out;
    logic            accept;
    logic            rank_hit;
    logic            slot_greater;
    logic [CW-1:0]   idx_m1, idx_m2, count_m1;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign idx_m1   = r_idx - CW'(1);
    assign idx_m2   = r_idx - CW'(2);
    assign count_m1 = r_count - CW'(1);
    assign rank_hit = {{CW{1'b0}}, i_read_rank} < {4'b0000, r_count};
    // A stored record moves up only when its key is strictly greater, which
    // keeps equal keys in arrival order.
    assign slot_greater = {i_mem_rdata.level, i_mem_rdata.age} > {r_new.level, r_new.age};
    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_new        = r_new;
        n_res_status = r_res_status;
        n_res_rank   = r_res_rank;
        n_res_rec    = r_res_rec;
        o_mem_req    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_new.level  = i_level;
                    n_new.age    = i_age;
                    n_new.id     = i_member_id;
                    n_res_rec    = '0;
                    n_res_status = sptab_pkg::ST_DONE;
                    n_res_rank   = 4'd0;
                    if (i_req_type == sptab_pkg::REQ_INSERT) begin
                        if (r_count == CW'(sptab_pkg::CAPACITY)) begin
                            n_res_status = sptab_pkg::ST_FULL;
                            n_state      = S_DONE;
                        end else if (r_count == '0) begin
                            n_idx   = '0;
                            n_state = S_PLACE;
                        end else begin
                            n_idx           = r_count;
                            o_mem_req.re    = 1'b1;
                            o_mem_req.raddr = count_m1[AW-1:0];
                            n_state         = S_SCAN;
                        end
                    end else begin
                        n_res_rank = i_read_rank;
                        if (rank_hit) begin
                            o_mem_req.re    = 1'b1;
                            o_mem_req.raddr = AW'(i_read_rank);
                            n_state         = S_RWAIT;
                        end else begin
                            n_res_status = sptab_pkg::ST_EMPTY;
                            n_state      = S_DONE;
                        end
                    end
                end
            end
            S_SCAN: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_idx[AW-1:0];
                if (slot_greater) begin
                    o_mem_req.wdata = i_mem_rdata;
                    n_idx           = idx_m1;
                    if (r_idx == CW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = idx_m2[AW-1:0];
                    end
                end else begin
                    o_mem_req.wdata = r_new;
                    n_res_rank      = 4'(r_idx);
                    n_count         = r_count + CW'(1);
                    n_state         = S_DONE;
                end
            end
            S_PLACE: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_idx[AW-1:0];
                o_mem_req.wdata = r_new;
                n_res_rank      = 4'(r_idx);
                n_count         = r_count + CW'(1);
                n_state         = S_DONE;
            end
            S_RWAIT: begin
                n_res_rec = i_mem_rdata;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_new        <= n_new;
        r_res_status <= n_res_status;
        r_res_rank   <= n_res_rank;
        r_res_rec    <= n_res_rec;
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_rank   <= r_res_rank;
            r_out_rec    <= r_res_rec;
            o_fill_count <= 5'(r_count);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_rank      = r_out_rank;
    assign o_out_level = r_out_rec.level;
    assign o_out_age   = r_out_rec.age;
    assign o_out_id    = r_out_rec.id;

endmodule
`default_nettype wire

// ===== hdl/sorted_priority_insert_table.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_stall   | req_type, level, age, member_id, read_rank
// out     | output    | o_out_valid / i_out_stall | status, rank, level, age, id, fill_count
//
// One beat in gives one beat out. An insert walks the table from the top stored
// rank down, one record per cycle through a one-read one-write record memory and
// one key comparator.
// Reset is synchronous and active low; it empties the table, no clearing pass.
// The input stalls while an item is in work or its result waits to enter the output register.
`default_nettype none
module sorted_priority_insert_table (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_req_type,
    input  wire  [3:0]  i_level,
    input  wire  [6:0]  i_age,
    input  wire  [15:0] i_member_id,
    input  wire  [3:0]  i_read_rank,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_rank,
    output logic [3:0]  o_out_level,
    output logic [6:0]  o_out_age,
    output logic [15:0] o_out_id,
    output logic [4:0]  o_fill_count
);

    sptab_pkg::t_mem_req mem_req;
    sptab_pkg::t_rec     mem_rdata;

    sptab_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_level      (i_level),
        .i_age        (i_age),
        .i_member_id  (i_member_id),
        .i_read_rank  (i_read_rank),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_rank       (o_rank),
        .o_out_level  (o_out_level),
        .o_out_age    (o_out_age),
        .o_out_id     (o_out_id),
        .o_fill_count (o_fill_count),
        .o_mem_req    (mem_req),
        .i_mem_rdata  (mem_rdata)
    );

    sptab_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule
`default_nettype wire

// ===== hdl/sptab_checker.sv =====
`default_nettype none
module sptab_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [1:0]  o_status,
    input wire [3:0]  o_rank,
    input wire [3:0]  o_out_level,
    input wire [6:0]  o_out_age,
    input wire [15:0] o_out_id,
    input wire [4:0]  o_fill_count
);

    // A stalled result beat stays and keeps its status, rank, id and fill count.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_rank) && $stable(o_out_id) && $stable(o_fill_count))
        else $error("stalled result beat changed");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> {27'd0, o_fill_count} <= 32'(sptab_pkg::CAPACITY))
        else $error("fill count above capacity");

    // A refused insert only happens on a full table and reports nothing else.
    a_full_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == sptab_pkg::ST_FULL |->
            {27'd0, o_fill_count} == 32'(sptab_pkg::CAPACITY) && o_rank == 4'd0
            && o_out_level == 4'd0 && o_out_age == 7'd0 && o_out_id == 16'd0)
        else $error("bad table-full result");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == sptab_pkg::ST_EMPTY |->
            {1'b0, o_rank} >= o_fill_count && o_out_level == 4'd0
            && o_out_age == 7'd0 && o_out_id == 16'd0)
        else $error("bad empty-rank result");

endmodule

bind sorted_priority_insert_table sptab_checker u_sptab_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_rank       (o_rank),
    .o_out_level  (o_out_level),
    .o_out_age    (o_out_age),
    .o_out_id     (o_out_id),
    .o_fill_count (o_fill_count)
);
`default_nettype wire
